FILE: hdl/thd_pkg.sv
// ----------------------------------------------------------------------------
// thd_pkg
// Shared widths, constants, types and tables of the THD-from-dB block.
// ----------------------------------------------------------------------------
`default_nettype none

package thd_pkg;

  // Item field widths
  localparam int LEVEL_W     = 16;
  localparam int THD_W       = 24;
  localparam int CNT_OUT_W   = 6;
  localparam int SUM_W       = 32;

  // Run length limit and counter width (must hold the limit itself)
  localparam int MAX_HARMONICS = 32;
  localparam int CNT_W         = $clog2(MAX_HARMONICS + 1);

  // Exponent constants: log2(10)/10 in Q24, ln2 in Q30
  localparam int L_Q24        = 5573271;
  localparam int LN2_Q30      = 744261118;
  localparam int TAYLOR_TERMS = 13;
  localparam int K_W          = 4;

  // Percent scale applied under the root: 100^2
  localparam int THD_SCALE = 10000;

  // Shared multiplier: signed operands, full product
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  // Square-root datapath width (even, covers sum * 10000)
  localparam int SQ_W = 48;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_EXPN,
    S_Y,
    S_TY,
    S_P,
    S_Q,
    S_C,
    S_SH,
    S_ADD,
    S_FIN,
    S_SQ0,
    S_SQ
  } state_t;

  // Status of the square-root unit
  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } sqrt_status_t;

  // floor(2^32 / k) for the Taylor divisors k = 2..13
  function automatic logic [31:0] recip(input logic [K_W-1:0] k);
    logic [31:0] r;
    case (k)
      4'd2:    r = 32'd2147483648;
      4'd3:    r = 32'd1431655765;
      4'd4:    r = 32'd1073741824;
      4'd5:    r = 32'd858993459;
      4'd6:    r = 32'd715827882;
      4'd7:    r = 32'd613566756;
      4'd8:    r = 32'd536870912;
      4'd9:    r = 32'd477218588;
      4'd10:   r = 32'd429496729;
      4'd11:   r = 32'd390451572;
      4'd12:   r = 32'd357913941;
      4'd13:   r = 32'd330382099;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/thd_in_if.sv
// ----------------------------------------------------------------------------
// thd_in_if
// Input channel: one harmonic level item per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface thd_in_if;
  import thd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [LEVEL_W-1:0] level_db;
  logic                      last;

  modport source (output valid, level_db, last, input ready);
  modport sink   (input valid, level_db, last, output ready);
endinterface

`default_nettype wire

FILE: hdl/thd_out_if.sv
// ----------------------------------------------------------------------------
// thd_out_if
// Output channel: one THD result item per run.
// ----------------------------------------------------------------------------
`default_nettype none

interface thd_out_if;
  import thd_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [THD_W-1:0]     thd_percent;
  logic                 saturated;
  logic                 too_many;
  logic [CNT_OUT_W-1:0] harmonic_count;

  modport source (output valid, thd_percent, saturated, too_many, harmonic_count,
                  input ready);
  modport sink   (input valid, thd_percent, saturated, too_many, harmonic_count,
                  output ready);
endinterface

`default_nettype wire

FILE: hdl/thd_mul.sv
// ----------------------------------------------------------------------------
// thd_mul
// Shared signed multiplier with a registered full-width product.
// ----------------------------------------------------------------------------
`default_nettype none

module thd_mul (
  input  wire logic                              clk,
  input  wire logic signed [thd_pkg::MUL_W-1:0]  a,
  input  wire logic signed [thd_pkg::MUL_W-1:0]  b,
  output logic signed      [thd_pkg::PROD_W-1:0] prod
);
  import thd_pkg::*;

  // Product lands in the cycle after the operands
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

`default_nettype wire

FILE: hdl/thd_sqrt.sv
// ----------------------------------------------------------------------------
// thd_sqrt
// Integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module thd_sqrt (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [thd_pkg::SQ_W-1:0]   x,
  output logic [thd_pkg::THD_W-1:0]       root_out,
  output thd_pkg::sqrt_status_t           status
);
  import thd_pkg::*;

  logic            busy;
  logic            done;
  logic [SQ_W-1:0] rem;
  logic [SQ_W-1:0] root;
  logic [SQ_W-1:0] one_r;
  logic [SQ_W-1:0] trial;

  assign trial = root + one_r;

  // Control: busy until the lowest bit pair is done
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && one_r[0]) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Restoring digit recurrence
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= x;
      root  <= '0;
      one_r <= {2'b01, {(SQ_W-2){1'b0}}};
    end else if (busy) begin
      if (rem >= trial) begin
        rem  <= rem - trial;
        root <= (root >> 1) + one_r;
      end else begin
        root <= root >> 1;
      end
      one_r <= one_r >> 2;
    end
  end

  assign root_out    = root[THD_W-1:0];
  assign status.busy = busy;
  assign status.done = done;
  assign status.ovf  = |root[SQ_W-1:THD_W];

endmodule

`default_nettype wire

FILE: hdl/thd_from_harmonic_db.sv
// ----------------------------------------------------------------------------
// thd_from_harmonic_db
// THD percent from a run of harmonic levels in dB, one shared multiplier.
// ----------------------------------------------------------------------------
// The first item of a run is the fundamental; each later item up to the run
// limit adds its power ratio 10^((level - fundamental)/10) to a saturating
// Q16.16 sum, and the item marked last also returns floor(sqrt(10000 * sum))
// as THD percent in Q16.8. The block takes one item at a time and drops ready
// while it works. A harmonic uses one shared 33x33 multiplier to form the
// exponent, then runs the first Taylor step and 12 more steps (multiply,
// reciprocal multiply, correction). Terms that clamp or vanish skip the
// series. A last item then goes through the root start, the 24-step square
// root and the output load. A finished result sits in an output register, so
// the next item is accepted while it waits; a second result stalls only if
// the first is still untaken.
`default_nettype none

module thd_from_harmonic_db (
  input wire logic  clk,
  input wire logic  rst,
  thd_in_if.sink    levels,
  thd_out_if.source results
);
  import thd_pkg::*;

  state_t state, state_next;

  // Run state
  logic signed [LEVEL_W-1:0] fund;
  logic [SUM_W-1:0]          sum;
  logic [CNT_W-1:0]          count;
  logic                      clamp;
  logic                      ovf;
  logic                      last_r;

  // Exponent datapath
  logic signed [8:0] n_reg;
  logic [29:0]       y_reg;
  logic [30:0]       term;
  logic [31:0]       e;
  logic [K_W-1:0]    k;
  logic [29:0]       p_reg;
  logic [29:0]       qe_reg;
  logic [SUM_W-1:0]  term_r;

  // Output register
  logic                 out_valid;
  logic [THD_W-1:0]     out_thd;
  logic                 out_sat;
  logic                 out_tm;
  logic [CNT_OUT_W-1:0] out_cnt;

  // Shared units
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic                     sq_start;
  logic [THD_W-1:0]         sq_root;
  sqrt_status_t             sq_st;

  // Decoded values
  logic                      accept;
  logic                      out_free;
  logic                      out_load;
  logic signed [LEVEL_W:0]   diff;
  logic signed [8:0]         n_val;
  logic [31:0]               f_val;
  logic [29:0]               y_val;
  logic [29:0]               p_val;
  logic [29:0]               qe_val;
  logic [29:0]               qk_val;
  logic [29:0]               r_val;
  logic [29:0]               q_val;
  logic signed [8:0]         rsh_s;
  logic [31:0]               shifted;
  logic [SUM_W:0]            sum_ext;
  logic [6:0]                cnt7;
  logic [CNT_OUT_W-1:0]      cnt_clip;

  thd_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  thd_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .x        (prod[SQ_W-1:0]),
    .root_out (sq_root),
    .status   (sq_st)
  );

  // Handshake and field decode
  assign levels.ready = (state == S_IDLE) && !rst;
  assign accept       = levels.valid && levels.ready;
  assign out_free     = !out_valid || results.ready;
  assign out_load     = (state == S_SQ) && !sq_st.busy && out_free;

  assign diff   = (LEVEL_W+1)'(levels.level_db) - (LEVEL_W+1)'(fund);
  assign n_val  = prod[40:32];
  assign f_val  = prod[31:0];
  assign y_val  = prod[61:32];
  assign p_val  = prod[59:30];
  assign qe_val = prod[61:32];
  assign qk_val = prod[29:0];
  assign r_val  = p_reg - qk_val;
  assign q_val  = (r_val >= 30'(k)) ? qe_reg + 30'd1 : qe_reg;

  // Scale the 2^frac value by 2^n (n = 14 or 15 shifts left by n - 14, smaller n shifts right)
  assign rsh_s   = 9'sd14 - n_reg;
  assign shifted = (n_reg >= 9'sd14) ? (e << n_reg[0]) : (e >> rsh_s[4:0]);

  assign sum_ext  = {1'b0, sum} + {1'b0, term_r};
  assign cnt7     = 7'(count);
  assign cnt_clip = (cnt7 > 7'd63) ? 6'd63 : cnt7[5:0];

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, multiplier operands, root start
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    sq_start   = 1'b0;
    case (state)
      S_IDLE: begin
        mul_a = MUL_W'(diff);
        mul_b = MUL_W'(L_Q24);
        if (accept) begin
          if (count == '0 || count >= CNT_W'(MAX_HARMONICS)) begin
            state_next = S_FIN;
          end else begin
            state_next = S_EXPN;
          end
        end
      end
      S_EXPN: begin
        mul_a = MUL_W'(f_val);
        mul_b = MUL_W'(LN2_Q30);
        if (n_val >= 9'sd16 || n_val <= -9'sd18) begin
          state_next = S_ADD;
        end else begin
          state_next = S_Y;
        end
      end
      S_Y: begin
        state_next = S_TY;
      end
      S_TY: begin
        mul_a      = MUL_W'(term);
        mul_b      = MUL_W'(y_reg);
        state_next = S_P;
      end
      S_P: begin
        mul_a = MUL_W'(p_val);
        mul_b = MUL_W'(recip(k));
        if (k == K_W'(1)) begin
          state_next = S_TY;
        end else begin
          state_next = S_Q;
        end
      end
      S_Q: begin
        mul_a      = MUL_W'(qe_val);
        mul_b      = MUL_W'(k);
        state_next = S_C;
      end
      S_C: begin
        if (k == K_W'(TAYLOR_TERMS)) begin
          state_next = S_SH;
        end else begin
          state_next = S_TY;
        end
      end
      S_SH: begin
        state_next = S_ADD;
      end
      S_ADD: begin
        state_next = S_FIN;
      end
      S_FIN: begin
        mul_a = MUL_W'(sum);
        mul_b = MUL_W'(THD_SCALE);
        if (last_r) begin
          state_next = S_SQ0;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SQ0: begin
        sq_start   = 1'b1;
        state_next = S_SQ;
      end
      S_SQ: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Run state: fundamental, sum, count and sticky flags
  always_ff @(posedge clk) begin
    if (rst) begin
      fund  <= '0;
      sum   <= '0;
      count <= '0;
      clamp <= 1'b0;
      ovf   <= 1'b0;
    end else begin
      if (accept) begin
        if (count == '0) begin
          fund  <= levels.level_db;
          sum   <= '0;
          clamp <= 1'b0;
          ovf   <= 1'b0;
          count <= CNT_W'(1);
        end else if (count >= CNT_W'(MAX_HARMONICS)) begin
          ovf <= 1'b1;
        end
      end
      if (state == S_EXPN && n_val >= 9'sd16) begin
        clamp <= 1'b1;
      end
      if (state == S_ADD) begin
        count <= count + CNT_W'(1);
        if (sum_ext[SUM_W]) begin
          sum   <= '1;
          clamp <= 1'b1;
        end else begin
          sum <= sum_ext[SUM_W-1:0];
        end
      end
      if (out_load) begin
        count <= '0;
        sum   <= '0;
        clamp <= 1'b0;
        ovf   <= 1'b0;
      end
    end
  end

  // Exponent series datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      last_r <= levels.last;
    end
    case (state)
      S_EXPN: begin
        n_reg <= n_val;
        if (n_val >= 9'sd16) begin
          term_r <= '1;
        end else if (n_val <= -9'sd18) begin
          term_r <= '0;
        end
      end
      S_Y: begin
        y_reg <= y_val;
        term  <= 31'h4000_0000;
        e     <= 32'h4000_0000;
        k     <= K_W'(1);
      end
      S_P: begin
        p_reg <= p_val;
        if (k == K_W'(1)) begin
          term <= 31'(p_val);
          e    <= e + 32'(p_val);
          k    <= K_W'(2);
        end
      end
      S_Q: begin
        qe_reg <= qe_val;
      end
      S_C: begin
        term <= 31'(q_val);
        e    <= e + 32'(q_val);
        k    <= k + K_W'(1);
      end
      S_SH: begin
        term_r <= shifted;
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_thd <= sq_st.ovf ? '1 : sq_root;
      out_sat <= clamp | sq_st.ovf;
      out_tm  <= ovf;
      out_cnt <= cnt_clip;
    end
  end

  assign results.valid          = out_valid;
  assign results.thd_percent    = out_thd;
  assign results.saturated      = out_sat;
  assign results.too_many       = out_tm;
  assign results.harmonic_count = out_cnt;

  // Checks
  a_sqrt_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    sq_st.done |-> state == S_SQ)
    else $error("root finished outside its wait state");

  a_div_correction: assert property (@(posedge clk) disable iff (rst)
    state == S_C |-> r_val < 30'({k, 1'b0}))
    else $error("reciprocal quotient off by more than one");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    state == S_ADD |=> count == $past(count) + CNT_W'(1))
    else $error("harmonic count did not advance");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_HARMONICS))
    else $error("harmonic count beyond run limit");

  a_emit_clears_run: assert property (@(posedge clk) disable iff (rst)
    out_load |=> results.valid && count == '0 && sum == '0)
    else $error("run state not cleared on emit");

endmodule

`default_nettype wire

FILE: bench/thd_from_harmonic_db_tb.sv
// ----------------------------------------------------------------------------
// thd_from_harmonic_db_tb
// Self-checking bench for the THD-from-dB block. A short table of level items
// (single-item runs, equal levels, huge and tiny ratios, sum overflow,
// exponent edge) is followed by random runs of random length, some of them past
// the harmonic limit. Every item is scored by a bit-true model of the exponent
// series, the saturating sum and the integer root, and every result item is
// compared field by field. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module thd_from_harmonic_db_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import thd_pkg::*;

  // Result item as seen on the output channel
  typedef struct packed {
    logic [THD_W-1:0]     thd;
    logic                 sat;
    logic                 many;
    logic [CNT_OUT_W-1:0] cnt;
  } thd_result_t;

  // One row of the directed table; want is used only where typed is set
  typedef struct packed {
    logic signed [LEVEL_W-1:0] lvl;
    logic                      lst;
    logic                      typed;
    thd_result_t               want;
  } stim_row_t;

  // Exponent math: log2(10)/10 in Q24, ln2 in Q30, integer part bias
  localparam longint          LOG2_10_Q24 = 5573271;
  localparam longint unsigned LN2_FRAC    = 744261118;
  localparam longint          EXP_OFFSET  = 128;
  localparam int              SERIES_LEN  = 13;
  localparam longint unsigned PERCENT_SQ  = 10000;

  localparam int RANDOM_ITEMS = 1850;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 120;
  localparam int IDLE_PCT     = 6;

  localparam thd_result_t NO_RESULT = '0;
  // 100.00 percent in Q16.8
  localparam logic [THD_W-1:0] THD_UNITY = 24'd25600;

  localparam int N_DIRECTED = 22;
  localparam stim_row_t DIRECTED [0:N_DIRECTED-1] = '{
    // single-item runs at zero and both extremes give zero THD
    '{16'sh0000, 1'b1, 1'b1, '{24'd0, 1'b0, 1'b0, 6'd1}},
    '{16'sh8000, 1'b1, 1'b1, '{24'd0, 1'b0, 1'b0, 6'd1}},
    '{16'sh7FFF, 1'b1, 1'b1, '{24'd0, 1'b0, 1'b0, 6'd1}},
    // harmonic equal to fundamental: ratio 1.0
    '{16'sh0A00, 1'b0, 1'b0, NO_RESULT},
    '{16'sh0A00, 1'b1, 1'b1, '{THD_UNITY, 1'b0, 1'b0, 6'd2}},
    // largest positive difference: term clamps
    '{16'sh8000, 1'b0, 1'b0, NO_RESULT},
    '{16'sh7FFF, 1'b1, 1'b0, NO_RESULT},
    // largest negative difference: term vanishes
    '{16'sh7FFF, 1'b0, 1'b0, NO_RESULT},
    '{16'sh8000, 1'b1, 1'b1, '{24'd0, 1'b0, 1'b0, 6'd2}},
    // two +48 dB harmonics overflow the sum
    '{16'sh0000, 1'b0, 1'b0, NO_RESULT},
    '{16'sh3000, 1'b0, 1'b0, NO_RESULT},
    '{16'sh3000, 1'b1, 1'b0, NO_RESULT},
    // ordinary run: -20 dB, -10 dB, -21 dB
    '{16'sh1400, 1'b0, 1'b0, NO_RESULT},
    '{16'sh0000, 1'b0, 1'b0, NO_RESULT},
    '{16'sh0A00, 1'b0, 1'b0, NO_RESULT},
    '{16'shFF00, 1'b1, 1'b0, NO_RESULT},
    // exponent edge: integer part 15, then 16 (clamp)
    '{16'sh0000, 1'b0, 1'b0, NO_RESULT},
    '{16'sh302A, 1'b0, 1'b0, NO_RESULT},
    '{16'sh302B, 1'b1, 1'b0, NO_RESULT},
    // one-step differences around the fundamental
    '{16'sh0000, 1'b0, 1'b0, NO_RESULT},
    '{16'sh0001, 1'b0, 1'b0, NO_RESULT},
    '{16'shFFFF, 1'b1, 1'b0, NO_RESULT}
  };

  logic clk;
  logic rst;
  logic calm;

  thd_in_if  levels_bus ();
  thd_out_if results_bus ();

  thd_from_harmonic_db dut (
    .clk     (clk),
    .rst     (rst),
    .levels  (levels_bus),
    .results (results_bus)
  );

  // Model state of the open run
  logic signed [LEVEL_W-1:0] fund_lvl;
  logic [SUM_W-1:0]          ratio_sum;
  int unsigned               run_len;
  bit                        run_clamped;
  bit                        run_long;

  thd_result_t pending_thd[$];

  int mismatches;
  int levels_sent;
  int runs_checked;
  int sat_runs;
  int long_runs;
  int cycle_count;

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Power ratio 10^(diff/10) in Q16.16 via 2^n * exp(f*ln2)
  function automatic logic [SUM_W-1:0] power_term(input int diff, output bit clamp);
    longint          t;
    longint unsigned ut, f, y, term, e;
    int              n;
    int unsigned     k;
    clamp = 1'b0;
    t  = longint'(diff) * LOG2_10_Q24;
    ut = longint'(t + (EXP_OFFSET << 32));
    n  = int'(ut >> 32) - int'(EXP_OFFSET);
    f  = ut & 64'hFFFF_FFFF;
    if (n >= 16) begin
      clamp = 1'b1;
      return '1;
    end
    y    = (f * LN2_FRAC) >> 32;
    term = 64'd1 << 30;
    e    = term;
    for (k = 1; k <= SERIES_LEN; k++) begin
      term = ((term * y) >> 30) / k;
      e += term;
    end
    if (n >= 14) return SUM_W'(e << (n - 14));
    if (14 - n >= 32) return '0;
    return SUM_W'(e >> (14 - n));
  endfunction

  // Integer square root, rounded down
  function automatic longint unsigned floor_sqrt(input longint unsigned x);
    longint unsigned rem, acc, bitv;
    rem  = x;
    acc  = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= acc + bitv) begin
        rem -= acc + bitv;
        acc = (acc >> 1) + bitv;
      end else begin
        acc >>= 1;
      end
      bitv >>= 2;
    end
    return acc;
  endfunction

  // Advance the run state by one level item; emit is set on a last item
  task automatic predict_thd(input logic signed [LEVEL_W-1:0] lvl, input logic lst,
                             output bit emit, output thd_result_t res);
    logic [SUM_W-1:0] term;
    logic [SUM_W:0]   wide;
    bit               clip;
    longint unsigned  root;
    emit = 1'b0;
    res  = NO_RESULT;
    if (run_len == 0) begin
      fund_lvl    = lvl;
      ratio_sum   = '0;
      run_clamped = 1'b0;
      run_long    = 1'b0;
      run_len     = 1;
    end else if (run_len >= MAX_HARMONICS) begin
      // past the limit: item ignored, run flagged
      run_long = 1'b1;
    end else begin
      term = power_term(int'(lvl) - int'(fund_lvl), clip);
      if (clip) run_clamped = 1'b1;
      wide = {1'b0, ratio_sum} + term;
      if (wide[SUM_W]) begin
        ratio_sum   = '1;
        run_clamped = 1'b1;
      end else begin
        ratio_sum = wide[SUM_W-1:0];
      end
      run_len++;
    end
    if (lst) begin
      root = floor_sqrt(longint'(ratio_sum) * PERCENT_SQ);
      if (root > 64'hFF_FFFF) begin
        root        = 64'hFF_FFFF;
        run_clamped = 1'b1;
      end
      res.thd  = root[THD_W-1:0];
      res.sat  = run_clamped;
      res.many = run_long;
      res.cnt  = (run_len > 63) ? 6'd63 : CNT_OUT_W'(run_len);
      emit     = 1'b1;
      run_len     = 0;
      ratio_sum   = '0;
      run_clamped = 1'b0;
      run_long    = 1'b0;
    end
  endtask

  // Drive one level item, with random idle cycles ahead of it
  task automatic send_level(input logic signed [LEVEL_W-1:0] lvl, input logic lst);
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        levels_bus.valid <= 1'b0;
        @(posedge clk);
      end
    end
    levels_bus.valid    <= 1'b1;
    levels_bus.level_db <= lvl;
    levels_bus.last     <= lst;
    do @(posedge clk); while (!levels_bus.ready);
  endtask

  // Send an item and queue what it should produce
  task automatic apply_level(input logic signed [LEVEL_W-1:0] lvl, input logic lst,
                             input bit use_typed, input thd_result_t typed_res);
    bit          emit;
    thd_result_t res;
    send_level(lvl, lst);
    levels_sent++;
    predict_thd(lvl, lst, emit, res);
    if (emit) pending_thd.push_back(use_typed ? typed_res : res);
  endtask

  function automatic logic signed [LEVEL_W-1:0] clip_level(input int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return LEVEL_W'(v);
  endfunction

  task automatic report_mismatch(input string what, input thd_result_t want,
                                 input thd_result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: want thd=%0d sat=%0b many=%0b cnt=%0d, got thd=%0d sat=%0b many=%0b cnt=%0d",
               $realtime, what, want.thd, want.sat, want.many, want.cnt,
               got.thd, got.sat, got.many, got.cnt);
  endtask

  // Score one accepted result item against the oldest expectation
  task automatic take_result();
    thd_result_t got, want;
    got = '{results_bus.thd_percent, results_bus.saturated, results_bus.too_many,
            results_bus.harmonic_count};
    if (pending_thd.size() == 0) begin
      report_mismatch("unexpected result", NO_RESULT, got);
    end else begin
      want = pending_thd.pop_front();
      runs_checked++;
      if (want.sat) sat_runs++;
      if (want.many) long_runs++;
      if (got !== want) report_mismatch("result mismatch", want, got);
    end
  endtask

  // Result side: score and stall at random
  always @(posedge clk) begin
    if (!rst && results_bus.valid && results_bus.ready) take_result();
    results_bus.ready <= !rst && (calm || $urandom_range(0, 99) >= IDLE_PCT);
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout at cycle %0d, %0d results outstanding", cycle_count,
               pending_thd.size());
      $display("thd_from_harmonic_db_tb: FAIL");
      $finish;
    end
  end

  initial begin
    int                        i, run_items, pick;
    logic signed [LEVEL_W-1:0] fund, lvl;
    rst                    = 1'b1;
    calm                   = 1'b0;
    levels_bus.valid       = 1'b0;
    levels_bus.level_db    = '0;
    levels_bus.last        = 1'b0;
    results_bus.ready      = 1'b0;
    cycle_count            = 0;
    mismatches             = 0;
    levels_sent            = 0;
    runs_checked           = 0;
    sat_runs               = 0;
    long_runs              = 0;
    fund_lvl               = '0;
    ratio_sum              = '0;
    run_len                = 0;
    run_clamped            = 1'b0;
    run_long               = 1'b0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    for (i = 0; i < N_DIRECTED; i++)
      apply_level(DIRECTED[i].lvl, DIRECTED[i].lst, DIRECTED[i].typed, DIRECTED[i].want);

    // Random runs: mostly short, some near and past the harmonic limit
    while (levels_sent < N_DIRECTED + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)      run_items = $urandom_range(2, 6);
      else if (pick < 60) run_items = 1;
      else if (pick < 75) run_items = $urandom_range(7, 20);
      else if (pick < 87) run_items = $urandom_range(28, 32);
      else                run_items = $urandom_range(33, 40);

      if ($urandom_range(0, 3) == 0) fund = LEVEL_W'($urandom);
      else fund = clip_level(int'($urandom_range(0, 24576)) - 8192);

      for (i = 0; i < run_items; i++) begin
        // quiet stretch with no idling on either side
        calm <= (levels_sent >= 700) && (levels_sent < 1100);
        if (i == 0) begin
          lvl = fund;
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 70)      lvl = clip_level(int'(fund) - int'($urandom_range(0, 20480)));
          else if (pick < 82) lvl = clip_level(int'(fund) + int'($urandom_range(0, 12800)));
          else                lvl = LEVEL_W'($urandom);
        end
        apply_level(lvl, i == run_items - 1, 1'b0, NO_RESULT);
      end
    end
    levels_bus.valid <= 1'b0;
    calm             <= 1'b0;

    // Drain, then watch for stray results
    while (pending_thd.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d level items in %0d runs checked, %0d mismatches", levels_sent,
             runs_checked, mismatches);
    $display("%0d runs saturated, %0d runs went past the harmonic limit", sat_runs,
             long_runs);
    if (mismatches == 0)
      $display("thd_from_harmonic_db_tb: PASS");
    else
      $display("thd_from_harmonic_db_tb: FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/thd_pkg.sv
hdl/thd_in_if.sv
hdl/thd_out_if.sv
hdl/thd_mul.sv
hdl/thd_sqrt.sv
hdl/thd_from_harmonic_db.sv
bench/thd_from_harmonic_db_tb.sv
